// File: src/ssdc_pkg.sv
// ---------------------------------------------------------------------------
// ssdc_pkg: shared types and constants
// Widths, micro-op table and unit command for the solid-solid drag block.
// ---------------------------------------------------------------------------
`default_nettype none
package ssdc_pkg;
	localparam int W = 260;          // shared accumulator width
	localparam int MW = 80;          // multiplier operand width
	localparam int QW = 49;          // quotient width: overflow bit and K
	localparam int SUMW = 40;
	localparam int STEPW = 5;
	localparam int CNTW = 6;
	localparam logic [STEPW-1:0] LAST_STEP = 5'd22;
	localparam logic [CNTW-1:0] K_STEPS = 6'd49;
	localparam logic [CNTW-1:0] P_STEPS = 6'd32;
	localparam logic [31:0] THREE_PI_16 = 32'd2529944570;
	localparam logic [19:0] MEGA = 20'd1000000;
	localparam logic [W-1:0] COEF_BASE = W'(49'd3) << 46;

	typedef enum logic [0:0] {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		A_T, A_TC, A_R1, A_R2, A_AG, A_DEN, A_D1, A_CF, A_AGSH
	} asel_t;

	typedef enum logic [3:0] {
		B_D1, B_D2, B_AG, B_DSUM, B_H, B_THREE, B_C32, B_E1, B_MEG,
		B_A1, B_A2, B_R1, B_R2, B_G, B_SUM
	} bsel_t;

	typedef enum logic [2:0] {
		D_NONE, D_DEN_SET, D_DEN_ADD, D_H, D_DV, D_G_SET, D_G_ADD
	} dst_t;

	typedef struct packed {
		asel_t a;
		bsel_t b;
		dst_t  d;
	} uop_t;

	typedef struct packed {
		logic            start;
		op_t             op;
		logic [CNTW-1:0] steps;
	} cmd_t;

	// Multiply program for the last item of a cell
	function automatic uop_t uop(input logic [STEPW-1:0] s);
		uop_t r;
		r = '{a: A_T, b: B_D1, d: D_NONE};
		unique case (s)
			5'd0:  r = '{a: A_R1,   b: B_D1,    d: D_NONE};
			5'd1:  r = '{a: A_T,    b: B_D1,    d: D_NONE};
			5'd2:  r = '{a: A_T,    b: B_D1,    d: D_DEN_SET};
			5'd3:  r = '{a: A_R2,   b: B_D2,    d: D_NONE};
			5'd4:  r = '{a: A_T,    b: B_D2,    d: D_NONE};
			5'd5:  r = '{a: A_T,    b: B_D2,    d: D_DEN_ADD};
			5'd6:  r = '{a: A_AG,   b: B_AG,    d: D_NONE};
			5'd7:  r = '{a: A_T,    b: B_DSUM,  d: D_H};
			5'd8:  r = '{a: A_DEN,  b: B_H,     d: D_DV};
			5'd9:  r = '{a: A_D1,   b: B_D2,    d: D_NONE};
			5'd10: r = '{a: A_T,    b: B_THREE, d: D_NONE};
			5'd11: r = '{a: A_T,    b: B_SUM,   d: D_G_SET};
			5'd12: r = '{a: A_AGSH, b: B_DSUM,  d: D_G_ADD};
			5'd13: r = '{a: A_CF,   b: B_C32,   d: D_NONE};
			5'd14: r = '{a: A_TC,   b: B_E1,    d: D_NONE};
			5'd15: r = '{a: A_T,    b: B_MEG,   d: D_NONE};
			5'd16: r = '{a: A_T,    b: B_A1,    d: D_NONE};
			5'd17: r = '{a: A_T,    b: B_A2,    d: D_NONE};
			5'd18: r = '{a: A_T,    b: B_R1,    d: D_NONE};
			5'd19: r = '{a: A_T,    b: B_R2,    d: D_NONE};
			5'd20: r = '{a: A_T,    b: B_DSUM,  d: D_NONE};
			5'd21: r = '{a: A_T,    b: B_DSUM,  d: D_NONE};
			5'd22: r = '{a: A_T,    b: B_G,     d: D_NONE};
			default: r = '{a: A_T, b: B_D1, d: D_NONE};
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// File: src/ssdc_cfg.sv
// ---------------------------------------------------------------------------
// ssdc_cfg: configuration registers
// APB-style write and read of restitution and friction coefficients.
// ---------------------------------------------------------------------------
`default_nettype none
module ssdc_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [15:0] restitution_q,
	output logic      [15:0] friction_q
);
	logic wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= 16'd58982;
			friction_q <= 16'd0;
		end else if (wr) begin
			if (paddr[2]) friction_q <= pwdata[15:0];
			else restitution_q <= pwdata[15:0];
		end
	end

	assign prdata = paddr[2] ? {16'd0, friction_q} : {16'd0, restitution_q};
endmodule
`default_nettype wire

// File: src/ssdc_unit.sv
// ---------------------------------------------------------------------------
// ssdc_unit: shared shift-add / shift-subtract unit
// Bit-serial multiply and restoring divide over one wide adder.
// ---------------------------------------------------------------------------
`default_nettype none
module ssdc_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ssdc_pkg::cmd_t               cmd,
	input  wire logic [ssdc_pkg::W-1:0]       opa,
	input  wire logic [ssdc_pkg::W-1:0]       opb,
	output logic                              busy,
	output logic [ssdc_pkg::W-1:0]            prod,
	output logic [ssdc_pkg::QW-1:0]           quot
);
	ssdc_pkg::op_t                mode_q;
	logic [ssdc_pkg::MW-1:0]      mp_q;
	logic [ssdc_pkg::CNTW-1:0]    cnt_q;
	logic [ssdc_pkg::W-1:0]       acc_q;
	logic [ssdc_pkg::W-1:0]       opr_q;
	logic [ssdc_pkg::QW-1:0]      q_q;
	logic [ssdc_pkg::W-1:0]       addsub;
	logic                         ge;

	assign busy = (mode_q == ssdc_pkg::OP_MUL) ? (|mp_q) : (|cnt_q);
	assign ge = acc_q >= opr_q;
	assign addsub = (mode_q == ssdc_pkg::OP_MUL) ? acc_q + opr_q : acc_q - opr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ssdc_pkg::OP_MUL;
			mp_q <= '0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			mode_q <= cmd.op;
			mp_q <= (cmd.op == ssdc_pkg::OP_MUL) ? opb[ssdc_pkg::MW-1:0] : '0;
			cnt_q <= (cmd.op == ssdc_pkg::OP_DIV) ? cmd.steps : '0;
		end else if (busy) begin
			mp_q <= mp_q >> 1;
			if (mode_q == ssdc_pkg::OP_DIV) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.op == ssdc_pkg::OP_MUL) begin
				acc_q <= '0;
				opr_q <= opa;
			end else begin
				acc_q <= opa;
				opr_q <= opb;
			end
			q_q <= '0;
		end else if (busy) begin
			if (mode_q == ssdc_pkg::OP_MUL) begin
				if (mp_q[0]) acc_q <= addsub;
				opr_q <= opr_q << 1;
			end else begin
				if (ge) acc_q <= addsub;
				q_q <= {q_q[ssdc_pkg::QW-2:0], ge};
				opr_q <= opr_q >> 1;
			end
		end
	end

	assign prod = acc_q;
	assign quot = q_q;
endmodule
`default_nettype wire

// File: src/solid_solid_drag_coefficient.sv
// ---------------------------------------------------------------------------
// solid_solid_drag_coefficient: solid-solid drag coefficient for one cell
// Sums fraction over diameter over a cell's solid phases, then forms K.
// ---------------------------------------------------------------------------
// Sequence: a non-solid item needs no unit operation; a solid item runs a 32-step
// divide with issue and finish and adds its quotient to the sum; the last item adds
// 23 multiplies of one step per multiplier bit plus issue and finish, a 49-step divide
// and output load. Throughput: one item at a time; in_ready is high only while idle.
// Reset: arst_n clears the sum, fault flag, sequencer and output valid, and
// loads restitution 58982 and friction 0.
`default_nettype none
module solid_solid_drag_coefficient (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] alpha_gas,
	input  wire logic [15:0] alpha_first,
	input  wire logic [15:0] alpha_second,
	input  wire logic [15:0] diameter_first,
	input  wire logic [15:0] diameter_second,
	input  wire logic [15:0] density_first,
	input  wire logic [15:0] density_second,
	input  wire logic [15:0] phase_alpha,
	input  wire logic [15:0] phase_diameter,
	input  wire logic        phase_is_solid,
	input  wire logic        last_phase,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [47:0] drag_coeff,
	output logic             saturated
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PDIV = 5'b00010,
		S_MUL  = 5'b00100,
		S_KDIV = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	localparam int WD = ssdc_pkg::W;

	state_t state_q;
	logic   issued_q;
	logic [ssdc_pkg::STEPW-1:0] step_q;
	logic [ssdc_pkg::SUMW-1:0]  sum_q;
	logic   fault_q;

	logic [15:0] restitution_q, friction_q;

	// captured request payload
	logic [15:0] ag_q, a1_q, a2_q, d1_q, d2_q, r1_q, r2_q, pa_q, pd_q;
	logic        last_q;

	// intermediate products
	logic [80:0]  den_q;
	logic [48:0]  h_q;
	logic [129:0] dv_q;
	logic [74:0]  g_q;

	logic [47:0] drag_q;
	logic        sat_q;
	logic        out_valid_q;

	ssdc_pkg::cmd_t cmd;
	ssdc_pkg::uop_t u;
	logic [WD-1:0] opa, opb, prod;
	logic [ssdc_pkg::QW-1:0] quot;
	logic busy;
	logic done;
	logic accept;
	logic [16:0] dsum;
	logic [40:0] sum_next;
	logic k_sat;
	logic load_out;

	ssdc_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.restitution_q(restitution_q), .friction_q(friction_q)
	);

	ssdc_unit u_unit (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .opa(opa), .opb(opb),
		.busy(busy), .prod(prod), .quot(quot)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid & in_ready;
	assign dsum = {1'b0, d1_q} + {1'b0, d2_q};
	assign u = ssdc_pkg::uop(step_q);
	assign done = issued_q & ~busy;
	assign sum_next = {1'b0, sum_q} + {9'd0, quot[31:0]};

	// Saturate on any fault, zero divisor, or a quotient overflow bit
	assign k_sat = fault_q | (ag_q == 16'd0) | (dsum == 17'd0) | (den_q == 81'd0) |
		quot[ssdc_pkg::QW-1];
	assign load_out = (state_q == S_OUT) & (~out_valid_q | out_ready);

	// Operand selection for the shared unit
	always_comb begin
		cmd.start = ~issued_q & ((state_q == S_PDIV) | (state_q == S_MUL) |
			(state_q == S_KDIV));
		cmd.op = ssdc_pkg::OP_MUL;
		cmd.steps = ssdc_pkg::K_STEPS;
		opa = '0;
		opb = '0;
		unique case (state_q)
			S_PDIV: begin
				cmd.op = ssdc_pkg::OP_DIV;
				cmd.steps = ssdc_pkg::P_STEPS;
				opa = WD'({pa_q, 16'd0});
				opb = WD'({pd_q, 31'd0});
			end
			S_KDIV: begin
				cmd.op = ssdc_pkg::OP_DIV;
				cmd.steps = ssdc_pkg::K_STEPS;
				opa = prod;
				opb = WD'({dv_q, 128'd0});
			end
			default: begin
				unique case (u.a)
					ssdc_pkg::A_T:    opa = prod;
					ssdc_pkg::A_TC:   opa = prod + ssdc_pkg::COEF_BASE;
					ssdc_pkg::A_R1:   opa = WD'(r1_q);
					ssdc_pkg::A_R2:   opa = WD'(r2_q);
					ssdc_pkg::A_AG:   opa = WD'(ag_q);
					ssdc_pkg::A_DEN:  opa = WD'(den_q);
					ssdc_pkg::A_D1:   opa = WD'(d1_q);
					ssdc_pkg::A_CF:   opa = WD'(friction_q);
					ssdc_pkg::A_AGSH: opa = WD'({ag_q, 16'd0});
					default:          opa = prod;
				endcase
				unique case (u.b)
					ssdc_pkg::B_D1:    opb = WD'(d1_q);
					ssdc_pkg::B_D2:    opb = WD'(d2_q);
					ssdc_pkg::B_AG:    opb = WD'(ag_q);
					ssdc_pkg::B_DSUM:  opb = WD'(dsum);
					ssdc_pkg::B_H:     opb = WD'(h_q);
					ssdc_pkg::B_THREE: opb = WD'(2'd3);
					ssdc_pkg::B_C32:   opb = WD'(ssdc_pkg::THREE_PI_16);
					ssdc_pkg::B_E1:    opb = WD'({1'b1, restitution_q});
					ssdc_pkg::B_MEG:   opb = WD'(ssdc_pkg::MEGA);
					ssdc_pkg::B_A1:    opb = WD'(a1_q);
					ssdc_pkg::B_A2:    opb = WD'(a2_q);
					ssdc_pkg::B_R1:    opb = WD'(r1_q);
					ssdc_pkg::B_R2:    opb = WD'(r2_q);
					ssdc_pkg::B_G:     opb = WD'(g_q);
					ssdc_pkg::B_SUM:   opb = WD'(sum_q);
					default:           opb = '0;
				endcase
			end
		endcase
	end

	// Sequencer: phase divide, multiply program, final divide, output load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			step_q <= '0;
			sum_q <= '0;
			fault_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) issued_q <= 1'b1;
			if (out_valid_q & out_ready & ~load_out) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (phase_is_solid & (phase_diameter != 16'd0)) begin
							state_q <= S_PDIV;
						end else begin
							// a solid phase with zero diameter poisons the cell
							if (phase_is_solid) fault_q <= 1'b1;
							if (last_phase) state_q <= S_MUL;
						end
					end
				end
				S_PDIV: begin
					if (done) begin
						issued_q <= 1'b0;
						if (sum_next[40]) begin
							sum_q <= '1;
							fault_q <= 1'b1;
						end else begin
							sum_q <= sum_next[39:0];
						end
						state_q <= last_q ? S_MUL : S_IDLE;
					end
				end
				S_MUL: begin
					if (done) begin
						issued_q <= 1'b0;
						if (step_q == ssdc_pkg::LAST_STEP) state_q <= S_KDIV;
						else step_q <= step_q + 1'b1;
					end
				end
				S_KDIV: begin
					if (done) begin
						issued_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						// hand off the result and drop the cell's accumulation
						out_valid_q <= 1'b1;
						sum_q <= '0;
						fault_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload capture and intermediate products
	always_ff @(posedge clk) begin
		if (accept) begin
			ag_q <= alpha_gas;
			a1_q <= alpha_first;
			a2_q <= alpha_second;
			d1_q <= diameter_first;
			d2_q <= diameter_second;
			r1_q <= density_first;
			r2_q <= density_second;
			pa_q <= phase_alpha;
			pd_q <= phase_diameter;
			last_q <= last_phase;
		end
		if ((state_q == S_MUL) & done) begin
			unique case (u.d)
				ssdc_pkg::D_DEN_SET: den_q <= prod[80:0];
				ssdc_pkg::D_DEN_ADD: den_q <= den_q + prod[80:0];
				ssdc_pkg::D_H:       h_q <= prod[48:0];
				ssdc_pkg::D_DV:      dv_q <= prod[129:0];
				ssdc_pkg::D_G_SET:   g_q <= prod[74:0];
				ssdc_pkg::D_G_ADD:   g_q <= g_q + prod[74:0];
				default: ;
			endcase
		end
		if (load_out) begin
			drag_q <= k_sat ? '1 : quot[47:0];
			sat_q <= k_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign drag_coeff = drag_q;
	assign saturated = sat_q;
endmodule
`default_nettype wire

// File: src/ssdc_chk.sv
// ---------------------------------------------------------------------------
// ssdc_chk: port checker
// Watches the top-level ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none
module ssdc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        last_phase,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [47:0] drag_coeff,
	input wire logic        saturated
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drag_coeff) && $stable(saturated))
		else $error("result changed while stalled");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> drag_coeff == 48'hFFFF_FFFF_FFFF)
		else $error("saturated result is not at maximum");

	a_new_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("new result while a request is in work");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_phase |=> !$rose(out_valid))
		else $error("result after a non-final request");
endmodule

bind solid_solid_drag_coefficient ssdc_chk u_ssdc_chk (.*);
`default_nettype wire

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for solid_solid_drag_coefficient
// Drives cells of phase requests with random gaps and stalls, predicts the
// drag coefficient K and the saturation flag in wide integer arithmetic,
// and checks every result in order against the prediction.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Register byte addresses
	localparam logic [2:0] ADDR_RESTITUTION = 3'd0;
	localparam logic [2:0] ADDR_FRICTION = 3'd4;

	localparam int CYCLE_LIMIT = 3000000;
	// Wait for a trailing last request to finish; leave margin
	localparam int SETTLE_CYCLES = 800;
	localparam int HOLD_OFF_CYCLES = 3000;

	typedef struct {
		logic [15:0] ag, a1, a2, d1, d2, r1, r2, pa, pd;
		logic        solid, last;
	} phase_req_t;

	typedef struct {
		logic [47:0] k;
		logic        sat;
	} drag_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] alpha_gas = '0, alpha_first = '0, alpha_second = '0;
	logic [15:0] diameter_first = 16'd1, diameter_second = 16'd1;
	logic [15:0] density_first = 16'd1, density_second = 16'd1;
	logic [15:0] phase_alpha = '0, phase_diameter = 16'd1;
	logic        phase_is_solid = 1'b0, last_phase = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [47:0] drag_coeff;
	logic        saturated;

	solid_solid_drag_coefficient dut (.*);

	always #10 clk = ~clk;

	// Predictor state: registers, running fraction/diameter sum, sticky fault
	logic [15:0] restitution_q = 16'd58982;
	logic [15:0] friction_q = 16'd0;
	logic [39:0] frac_sum = '0;
	logic        sum_fault = 1'b0;

	drag_result_t expected_drags[$];
	int          mismatches = 0;
	int unsigned cycles = 0;
	bit          quiet = 1'b0;      // no gaps or stalls on either side
	int          hold_off_req = 0;  // receiver hold-off length, picked up once

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp, cycles);
	endtask

	// Advance the sum and, on a last request, form K exactly
	function automatic bit predict_drag(input phase_req_t r, output drag_result_t res);
		logic [383:0] num, div, q, t, den;
		logic [63:0]  coef;
		logic [40:0]  nsum;
		logic [16:0]  dsum;
		bit           sat;
		if (r.solid) begin
			if (r.pd == 0) begin
				sum_fault = 1'b1;
			end else begin
				nsum = {1'b0, frac_sum} + 41'(({16'd0, r.pa, 16'd0}) / r.pd);
				if (nsum[40]) begin
					frac_sum = '1;
					sum_fault = 1'b1;
				end else begin
					frac_sum = nsum[39:0];
				end
			end
		end
		if (!r.last)
			return 1'b0;
		dsum = 17'(r.d1) + 17'(r.d2);
		den = 384'(r.r1) * r.d1 * r.d1 * r.d1 + 384'(r.r2) * r.d2 * r.d2 * r.d2;
		sat = sum_fault || r.ag == 0 || dsum == 0 || den == 0;
		res.k = '0;
		if (!sat) begin
			coef = (64'd3 << 46) + 64'd2529944570 * friction_q;
			// g0 numerator, over ag^2 * dsum in raw Q0.16 units
			t = 384'(r.d1) * r.d2 * 3 * frac_sum + ((384'(r.ag) << 16) * dsum);
			num = 384'(coef) * (384'd65536 + restitution_q) * 384'd1000000;
			num = num * r.a1 * r.a2 * r.r1 * r.r2 * dsum * dsum * t;
			div = (den * r.ag * r.ag * dsum) << 80;
			q = num / div;
			if (q >= (384'd1 << 48))
				sat = 1'b1;
			else
				res.k = q[47:0];
		end
		if (sat)
			res.k = '1;
		res.sat = sat;
		frac_sum = '0;
		sum_fault = 1'b0;
		return 1'b1;
	endfunction

	// Offer one request after a random gap, hold it until accepted
	task automatic send_request(input phase_req_t r);
		int gap;
		drag_result_t res;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		alpha_gas <= r.ag;
		alpha_first <= r.a1;
		alpha_second <= r.a2;
		diameter_first <= r.d1;
		diameter_second <= r.d2;
		density_first <= r.r1;
		density_second <= r.r2;
		phase_alpha <= r.pa;
		phase_diameter <= r.pd;
		phase_is_solid <= r.solid;
		last_phase <= r.last;
		do @(posedge clk); while (!in_ready);
		if (predict_drag(r, res))
			expected_drags.push_back(res);
	endtask

	// Drop valid at the edge that accepted the last request
	task automatic drop_valid();
		in_valid <= 1'b0;
	endtask

	// Wait out every expected result, then let any trailing request finish
	task automatic drain();
		drop_valid();
		while (expected_drags.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'($urandom_range(0, 65535)), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_RESTITUTION)
			restitution_q = val;
		else
			friction_q = val;
	endtask

	function automatic logic [15:0] pick16(input int lo);
		case ($urandom_range(0, 7))
			0: return 16'(lo);
			1: return 16'hffff;
			2: return 16'($urandom_range(lo, 255));
			default: return 16'($urandom_range(lo, 65535));
		endcase
	endfunction

	function automatic phase_req_t rand_phase(input bit last);
		phase_req_t r;
		r.ag = pick16(0);
		r.a1 = pick16(0);
		r.a2 = pick16(0);
		// rarely a zero diameter or density, to reach the zero-divisor cases
		r.d1 = pick16($urandom_range(0, 19) == 0 ? 0 : 1);
		r.d2 = pick16($urandom_range(0, 19) == 0 ? 0 : 1);
		r.r1 = pick16($urandom_range(0, 19) == 0 ? 0 : 1);
		r.r2 = pick16($urandom_range(0, 19) == 0 ? 0 : 1);
		r.pa = pick16(0);
		r.pd = pick16($urandom_range(0, 29) == 0 ? 0 : 1);
		r.solid = ($urandom_range(0, 3) != 0);
		r.last = last;
		return r;
	endfunction

	// One well-formed cell: up to three inner phases, then the last one
	task automatic send_cell(output int count);
		int n;
		n = $urandom_range(0, 3);
		repeat (n) send_request(rand_phase(1'b0));
		send_request(rand_phase(1'b1));
		count = n + 1;
	endtask

	task automatic test_directed();
		phase_req_t r;
		r = '{ag: 16'hffff, a1: 16'hffff, a2: 16'hffff, d1: 16'hffff, d2: 16'hffff,
			r1: 16'hffff, r2: 16'hffff, pa: 16'hffff, pd: 16'hffff, solid: 1'b1, last: 1'b1};
		send_request(r);
		// moderate cell that should not saturate
		r = '{ag: 16'd40000, a1: 16'd8000, a2: 16'd6000, d1: 16'd200, d2: 16'd400,
			r1: 16'd2500, r2: 16'd1500, pa: 16'd8000, pd: 16'd200, solid: 1'b1, last: 1'b0};
		send_request(r);
		r.pa = 16'd6000; r.pd = 16'd400;
		send_request(r);
		r.solid = 1'b0; r.pa = 16'hffff; r.pd = 16'd1;
		send_request(r);
		r.last = 1'b1; r.solid = 1'b1; r.pa = 16'd0;
		send_request(r);
		// zero phase diameter on a solid phase faults the cell
		r.pd = 16'd0; r.pa = 16'd100;
		send_request(r);
		// zero phase diameter on a non-solid phase is ignored
		r.solid = 1'b0;
		send_request(r);
		// gas fraction zero
		r.ag = 16'd0; r.pd = 16'd5;
		send_request(r);
		// zero diameters: zero diameter sum and denominator
		r.ag = 16'd30000; r.d1 = 16'd0; r.d2 = 16'd0;
		send_request(r);
		// zero densities: zero denominator
		r.d1 = 16'd1; r.d2 = 16'd1; r.r1 = 16'd0; r.r2 = 16'd0;
		send_request(r);
		// minimal diameters and fractions
		r = '{ag: 16'd1, a1: 16'd1, a2: 16'd1, d1: 16'd1, d2: 16'd1,
			r1: 16'd1, r2: 16'd1, pa: 16'd1, pd: 16'd1, solid: 1'b1, last: 1'b1};
		send_request(r);
		r.a1 = 16'd0;
		send_request(r);
		r = '{ag: 16'hffff, a1: 16'd3, a2: 16'd5, d1: 16'hffff, d2: 16'd1,
			r1: 16'd1, r2: 16'hffff, pa: 16'd0, pd: 16'hffff, solid: 1'b0, last: 1'b1};
		send_request(r);
		drain();
	endtask

	// Push the running sum past its 40-bit range
	task automatic test_sum_clamp();
		phase_req_t r;
		r = '{ag: 16'd50000, a1: 16'd100, a2: 16'd100, d1: 16'd100, d2: 16'd100,
			r1: 16'd1000, r2: 16'd1000, pa: 16'hffff, pd: 16'd1, solid: 1'b1, last: 1'b0};
		quiet = 1'b1;
		repeat (258) send_request(r);
		r.last = 1'b1;
		send_request(r);
		quiet = 1'b0;
		drain();
	endtask

	task automatic test_random_cells(input int n_reqs);
		int sent;
		int cnt;
		sent = 0;
		while (sent < n_reqs) begin
			// alternate stretches with and without idling
			if ($urandom_range(0, 15) == 0)
				quiet = ~quiet;
			send_cell(cnt);
			sent += cnt;
		end
		quiet = 1'b0;
		drain();
	endtask

	// Receiver holds off while more cells queue up behind the pending result
	task automatic test_backpressure();
		int cnt;
		hold_off_req = HOLD_OFF_CYCLES;
		repeat (5) send_cell(cnt);
		// pause until every result is in, then carry on
		drop_valid();
		while (expected_drags.size() != 0)
			@(posedge clk);
		repeat (4) send_cell(cnt);
		drain();
	endtask

	task automatic test_config_sweep();
		write_reg(ADDR_RESTITUTION, 16'hffff);
		write_reg(ADDR_FRICTION, 16'hffff);
		test_random_cells(400);
		write_reg(ADDR_RESTITUTION, 16'd0);
		write_reg(ADDR_FRICTION, 16'd0);
		test_random_cells(300);
		write_reg(ADDR_RESTITUTION, 16'($urandom_range(0, 65535)));
		write_reg(ADDR_FRICTION, 16'($urandom_range(0, 65535)));
		test_random_cells(300);
	endtask

	// Result receiver: random stall per result, long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 9);
			if (hold_off_req > 0) begin
				stall = hold_off_req;
				hold_off_req = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		drag_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_drags.size() == 0) begin
				report("unexpected result", 64'(drag_coeff), 64'd0);
			end else begin
				e = expected_drags.pop_front();
				if (drag_coeff !== e.k)
					report("drag_coeff", 64'(drag_coeff), 64'(e.k));
				if (saturated !== e.sat)
					report("saturated", 64'(saturated), 64'(e.sat));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_sum_clamp();
		test_random_cells(350);
		test_backpressure();
		test_config_sweep();
		if (mismatches == 0 && expected_drags.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (expected_drags.size() != 0)
				report("results never arrived", 64'(expected_drags.size()), 64'd0);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
